@@ hdl/ptsg_pkg.sv @@
// Shared constants, types and elaboration-time tables for the paging tone generator.
`timescale 1ns / 1ps

package ptsg_pkg;

  localparam int SINE_INDEX_BITS = 10;
  localparam int SAMPLE_RATE     = 44100;
  localparam int QUARTER_BITS    = SINE_INDEX_BITS - 2;
  localparam int SINE_QUARTER    = 1 << QUARTER_BITS;

  localparam int PHASE_W    = 32;
  localparam int CELL_W     = 8;
  localparam int CELL_COUNT = PHASE_W / CELL_W;

  localparam int SYMBOL_W   = 5;
  localparam int DURATION_W = 16;
  localparam int NOISE_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 15;
  localparam int DIGIT_W    = 4;
  localparam int TENTHS_W   = 14;

  localparam int NUM_TONES = 17;
  localparam logic [SYMBOL_W-1:0] REPEAT_TONE = 5'd16;
  localparam logic [SYMBOL_W-1:0] MAX_DIGIT   = 5'd9;

  localparam logic [GAIN_W-1:0] DRIVE_GAIN_RST = 16'd29491;
  localparam logic [GAIN_W-1:0] NOISE_GAIN_RST = 16'd5898;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_GAIN = 1'b1;

  localparam logic [63:0] TWO_PI_Q45 = 64'h0000_C90F_DAA2_2168;
  localparam logic [63:0] ONE_Q31    = 64'h0000_0000_8000_0000;
  localparam logic [63:0] MAG_MAX    = 64'd32767;

  typedef struct packed {
    logic load;
    logic advance;
  } acc_ctrl_t;

  typedef struct packed {
    logic active;
    logic last;
  } item_flags_t;

  typedef logic [TENTHS_W-1:0] tenths_tab_t [NUM_TONES];
  typedef logic [PHASE_W-1:0]  step_tab_t   [NUM_TONES];
  typedef logic [MAG_W-1:0]    sine_lut_t   [SINE_QUARTER+1];

  localparam tenths_tab_t TONE_TENTHS_HZ = '{
    14'd9798, 14'd9031, 14'd8325, 14'd7674, 14'd7074, 14'd6520, 14'd6010, 14'd5540,
    14'd5107, 14'd4708, 14'd4339, 14'd4000, 14'd3687, 14'd3399, 14'd3133, 14'd11531,
    14'd10629
  };

  function automatic step_tab_t build_step_tab();
    step_tab_t   tab;
    logic [63:0] num;
    for (int i = 0; i < NUM_TONES; i++) begin
      num    = (64'(TONE_TENTHS_HZ[i]) << 32) + 64'(5 * SAMPLE_RATE);
      tab[i] = PHASE_W'(num / 64'(10 * SAMPLE_RATE));
    end
    return tab;
  endfunction

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t   lut;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] mag;
    for (int r = 0; r <= SINE_QUARTER; r++) begin
      x  = (64'(r) * TWO_PI_Q45 + (64'd1 << (13 + SINE_INDEX_BITS))) >> (14 + SINE_INDEX_BITS);
      x2 = (x * x) >> 31;
      t  = ONE_Q31;
      for (int n = 9; n >= 1; n--) begin
        t = ONE_Q31 - (((x2 * t) >> 31) / 64'((2 * n) * (2 * n + 1)));
      end
      s   = (x * t) >> 31;
      mag = (MAG_MAX * s + (64'd1 << 30)) >> 31;
      if (mag > MAG_MAX) begin
        mag = MAG_MAX;
      end
      lut[r] = MAG_W'(mag);
    end
    return lut;
  endfunction

  localparam step_tab_t STEP_TAB = build_step_tab();
  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

@@ hdl/ptsg_if.sv @@
// Item channel interfaces for the paging tone generator.
`timescale 1ns / 1ps

interface ptsg_in_if;
  logic                                valid;
  logic                                ready;
  logic                                start_req;
  logic [ptsg_pkg::SYMBOL_W-1:0]       symbol;
  logic                                is_digit;
  logic                                first_of_number;
  logic [ptsg_pkg::DURATION_W-1:0]     duration;
  logic [ptsg_pkg::NOISE_W-1:0]        noise;

  modport source (
    output valid, start_req, symbol, is_digit, first_of_number, duration, noise,
    input  ready
  );
  modport sink (
    input  valid, start_req, symbol, is_digit, first_of_number, duration, noise,
    output ready
  );
endinterface

interface ptsg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ptsg_pkg::SAMPLE_W-1:0] sample;
  logic                                active;
  logic                                last;

  modport source (
    output valid, sample, active, last,
    input  ready
  );
  modport sink (
    input  valid, sample, active, last,
    output ready
  );
endinterface

@@ hdl/ptsg_acc_cell.sv @@
// One slice cell of the phase accumulator chain.
`timescale 1ns / 1ps

module ptsg_acc_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ptsg_pkg::acc_ctrl_t         ctrl,
  input  logic [ptsg_pkg::CELL_W-1:0] step_in,
  input  logic                        carry_in,
  output logic [ptsg_pkg::CELL_W-1:0] sum_out,
  output logic                        carry_out
);
  import ptsg_pkg::*;

  logic [CELL_W-1:0] phase_r, phase_nxt;
  logic [CELL_W-1:0] step_r, step_nxt;
  logic [CELL_W-1:0] base;

  always_comb begin
    base     = ctrl.load ? '0 : phase_r;
    step_nxt = ctrl.load ? step_in : step_r;
    {carry_out, sum_out} = {1'b0, base} + {1'b0, step_nxt} + {{CELL_W{1'b0}}, carry_in};
    phase_nxt = phase_r;
    if (ctrl.advance) begin
      phase_nxt = sum_out;
    end else if (ctrl.load) begin
      phase_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      step_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

@@ hdl/ptsg_tone_ctrl.sv @@
// Tone selection, digit repeat tracking and sample countdown.
`timescale 1ns / 1ps

module ptsg_tone_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic                            start_req,
  input  logic [ptsg_pkg::SYMBOL_W-1:0]   symbol,
  input  logic                            is_digit,
  input  logic                            first_of_number,
  input  logic [ptsg_pkg::DURATION_W-1:0] duration,
  output ptsg_pkg::acc_ctrl_t             acc_ctrl,
  output logic [ptsg_pkg::PHASE_W-1:0]    step_sel,
  output ptsg_pkg::item_flags_t           flags
);
  import ptsg_pkg::*;

  logic [DURATION_W-1:0] samples_left_r, samples_left_nxt;
  logic [DIGIT_W-1:0]    previous_digit_r, previous_digit_nxt;
  logic                  was_replaced_r, was_replaced_nxt;
  logic [SYMBOL_W-1:0]   sym_sat;
  logic [SYMBOL_W-1:0]   tone;
  logic [DURATION_W-1:0] left_eff;

  always_comb begin
    sym_sat            = (symbol > REPEAT_TONE) ? REPEAT_TONE : symbol;
    tone               = sym_sat;
    previous_digit_nxt = previous_digit_r;
    was_replaced_nxt   = was_replaced_r;
    if (is_digit && sym_sat <= MAX_DIGIT) begin
      if (first_of_number) begin
        was_replaced_nxt = 1'b0;
      end else if (sym_sat[DIGIT_W-1:0] == previous_digit_r) begin
        if (was_replaced_r) begin
          was_replaced_nxt = 1'b0;
        end else begin
          tone             = REPEAT_TONE;
          was_replaced_nxt = 1'b1;
        end
      end else begin
        was_replaced_nxt = 1'b0;
      end
      previous_digit_nxt = sym_sat[DIGIT_W-1:0];
    end

    step_sel         = STEP_TAB[tone];
    left_eff         = start_req ? duration : samples_left_r;
    flags.active     = (left_eff != '0);
    flags.last       = (left_eff == DURATION_W'(1));
    samples_left_nxt = flags.active ? left_eff - DURATION_W'(1) : left_eff;
    acc_ctrl.load    = accept && start_req;
    acc_ctrl.advance = accept && flags.active;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_left_r   <= '0;
      previous_digit_r <= '0;
      was_replaced_r   <= 1'b0;
    end else if (accept) begin
      samples_left_r <= samples_left_nxt;
      if (start_req) begin
        previous_digit_r <= previous_digit_nxt;
        was_replaced_r   <= was_replaced_nxt;
      end
    end
  end

endmodule

@@ hdl/ptsg_shaper.sv @@
// Sine look-up, gain scaling, noise mixing and clipping pipeline.
`timescale 1ns / 1ps

module ptsg_shaper (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ptsg_pkg::item_flags_t                in_flags,
  input  logic [ptsg_pkg::SINE_INDEX_BITS-1:0] in_k,
  input  logic [ptsg_pkg::NOISE_W-1:0]         in_noise,
  input  logic [ptsg_pkg::GAIN_W-1:0]          drive_gain,
  input  logic [ptsg_pkg::GAIN_W-1:0]          noise_gain,
  ptsg_out_if.source                           out_ch
);
  import ptsg_pkg::*;

  localparam int IDX_W  = QUARTER_BITS + 1;
  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
  localparam int SCL_W  = PROD_W - 15;
  localparam int SUM_W  = SCL_W + 1;
  localparam logic signed [SUM_W-1:0] CLIP_HI = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] CLIP_LO = -SUM_W'(32767);

  logic                        v1_r, v2_r, v3_r, vo_r;
  logic                        adv1, adv2, adv3, advo;
  item_flags_t                 f1_r, f2_r, f3_r;
  logic [SINE_INDEX_BITS-1:0]  k1_r;
  logic [NOISE_W-1:0]          noise1_r;
  logic signed [SAMPLE_W-1:0]  sine2_r, sine_nxt;
  logic [NOISE_W-1:0]          nterm2_r, nterm3_r;
  logic [NOISE_W+GAIN_W-1:0]   noise_prod;
  logic signed [PROD_W-1:0]    prod3_r, prod_nxt;
  logic [1:0]                  quad;
  logic [IDX_W-1:0]            lut_idx;
  logic [MAG_W-1:0]            mag;
  logic signed [SCL_W-1:0]     scaled;
  logic signed [SUM_W-1:0]     mix;
  logic signed [SAMPLE_W-1:0]  sample_nxt;
  logic signed [SAMPLE_W-1:0]  sample_r;
  logic                        active_r, last_r;

  assign advo     = !vo_r || out_ch.ready;
  assign adv3     = !v3_r || advo;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  always_comb begin
    quad     = k1_r[SINE_INDEX_BITS-1 -: 2];
    lut_idx  = quad[0] ? IDX_W'(SINE_QUARTER) - {1'b0, k1_r[QUARTER_BITS-1:0]}
                       : {1'b0, k1_r[QUARTER_BITS-1:0]};
    mag      = SINE_LUT[lut_idx];
    sine_nxt = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    noise_prod = noise1_r * noise_gain;
    prod_nxt   = sine2_r * $signed({1'b0, drive_gain});
    scaled     = prod3_r[PROD_W-1:15];
    mix        = $signed({scaled[SCL_W-1], scaled}) + $signed({{(SUM_W-NOISE_W){1'b0}}, nterm3_r});
    if (!f3_r.active) begin
      sample_nxt = '0;
    end else if (mix > CLIP_HI) begin
      sample_nxt = SAMPLE_W'(CLIP_HI);
    end else if (mix < CLIP_LO) begin
      sample_nxt = SAMPLE_W'(CLIP_LO);
    end else begin
      sample_nxt = mix[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (advo) vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      f1_r     <= in_flags;
      k1_r     <= in_k;
      noise1_r <= in_noise;
    end
    if (adv2 && v1_r) begin
      f2_r     <= f1_r;
      sine2_r  <= sine_nxt;
      nterm2_r <= noise_prod[NOISE_W+GAIN_W-1:GAIN_W];
    end
    if (adv3 && v2_r) begin
      f3_r     <= f2_r;
      prod3_r  <= prod_nxt;
      nterm3_r <= nterm2_r;
    end
    if (advo && v3_r) begin
      sample_r <= sample_nxt;
      active_r <= f3_r.active;
      last_r   <= f3_r.last;
    end
  end

  assign out_ch.valid  = vo_r;
  assign out_ch.sample = sample_r;
  assign out_ch.active = active_r;
  assign out_ch.last   = last_r;

endmodule

@@ hdl/paging_tone_sequence_generator.sv @@
// Top level of the paging tone generator: config registers, control, accumulator chain, shaper.
`timescale 1ns / 1ps

// Takes one item per clock cycle unless back-pressured and returns one result item
// for each, four register stages later (control and phase, sine look-up with noise
// scaling, drive gain multiply, mix and clip into the output register). The phase
// accumulator is a chain of four 8-bit cells whose carries ripple within the cycle;
// that chain and the 16x16 gain multipliers set the clock period. The sine comes
// from a quarter-wave table of 257 entries built at elaboration. Gains must be written
// through the cfg port only while no item is in flight; the block does not enforce this.
module paging_tone_sequence_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  ptsg_in_if.sink                             in_ch,
  ptsg_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [ptsg_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [ptsg_pkg::GAIN_W-1:0]         cfg_wdata
);
  import ptsg_pkg::*;

  logic [GAIN_W-1:0]  drive_gain_r;
  logic [GAIN_W-1:0]  noise_gain_r;
  logic               in_ready;
  logic               accept;
  acc_ctrl_t          acc_ctrl;
  item_flags_t        flags;
  logic [PHASE_W-1:0] step_sel;
  logic [PHASE_W-1:0] phase_sum;
  logic [CELL_COUNT:0] carry;

  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_gain_r <= DRIVE_GAIN_RST;
      noise_gain_r <= NOISE_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DRIVE_GAIN: drive_gain_r <= cfg_wdata;
        CFG_NOISE_GAIN: noise_gain_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ptsg_tone_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .start_req       (in_ch.start_req),
    .symbol          (in_ch.symbol),
    .is_digit        (in_ch.is_digit),
    .first_of_number (in_ch.first_of_number),
    .duration        (in_ch.duration),
    .acc_ctrl        (acc_ctrl),
    .step_sel        (step_sel),
    .flags           (flags)
  );

  assign carry[0] = 1'b0;

  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    ptsg_acc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (acc_ctrl),
      .step_in   (step_sel[i*CELL_W +: CELL_W]),
      .carry_in  (carry[i]),
      .sum_out   (phase_sum[i*CELL_W +: CELL_W]),
      .carry_out (carry[i+1])
    );
  end

  ptsg_shaper u_shaper (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (accept),
    .in_ready   (in_ready),
    .in_flags   (flags),
    .in_k       (phase_sum[PHASE_W-1 -: SINE_INDEX_BITS]),
    .in_noise   (in_ch.noise),
    .drive_gain (drive_gain_r),
    .noise_gain (noise_gain_r),
    .out_ch     (out_ch)
  );

endmodule

@@ tb/sv/ptsg_tone_check_pkg.sv @@
// Item types and scoreboard with its own tone predictor for the paging tone generator testbench.
`timescale 1ns / 1ps

package ptsg_tone_check_pkg;

  import ptsg_pkg::*;

  localparam int K_BITS       = SINE_INDEX_BITS;
  localparam int QUARTER_SPAN = 1 << (K_BITS - 2);
  localparam int MAX_REPORTS  = 10;
  localparam int FULL_SCALE   = 32767;
  localparam int IDLE_SYMBOL  = 15;

  localparam logic [63:0] TAU_Q45  = 64'h0000_C90F_DAA2_2168;
  localparam logic [63:0] UNIT_Q31 = 64'h0000_0000_8000_0000;

  localparam int TONE_DECIHZ [NUM_TONES] = '{
    9798, 9031, 8325, 7674, 7074, 6520, 6010, 5540, 5107, 4708,
    4339, 4000, 3687, 3399, 3133, 11531, 10629
  };

  typedef struct packed {
    logic                  start_req;
    logic [SYMBOL_W-1:0]   symbol;
    logic                  is_digit;
    logic                  first_of_number;
    logic [DURATION_W-1:0] duration;
    logic [NOISE_W-1:0]    noise;
  } tone_tick_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       active;
    logic                       last;
  } tone_sample_t;

  class tone_scoreboard;
    logic [GAIN_W-1:0]     drive_gain;
    logic [GAIN_W-1:0]     noise_gain;
    logic [PHASE_W-1:0]    phase_acc;
    logic [PHASE_W-1:0]    phase_inc;
    logic [DURATION_W-1:0] samples_left;
    logic [DIGIT_W-1:0]    prev_digit;
    logic                  was_replaced;
    tone_sample_t          expected_samples[$];
    int                    mismatches;

    function new();
      drive_gain   = DRIVE_GAIN_RST;
      noise_gain   = NOISE_GAIN_RST;
      phase_acc    = '0;
      phase_inc    = '0;
      samples_left = '0;
      prev_digit   = '0;
      was_replaced = 1'b0;
      mismatches   = 0;
    endfunction

    function void set_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
      case (idx)
        CFG_DRIVE_GAIN: drive_gain = value;
        CFG_NOISE_GAIN: noise_gain = value;
        default: ;
      endcase
    endfunction

    function logic [PHASE_W-1:0] phase_inc_for(int tone);
      logic [63:0] num;
      num = (64'(TONE_DECIHZ[tone]) << 32) + 64'(5 * SAMPLE_RATE);
      return PHASE_W'(num / 64'(10 * SAMPLE_RATE));
    endfunction

    function longint sine_of(int k);
      int          q;
      int          n;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] mag;
      q = (k >> (K_BITS - 2)) & 3;
      r = 64'(k & (QUARTER_SPAN - 1));
      if ((q & 1) != 0) begin
        r = 64'(QUARTER_SPAN) - r;
      end
      x  = (r * TAU_Q45 + (64'd1 << (13 + K_BITS))) >> (14 + K_BITS);
      x2 = (x * x) >> 31;
      t  = UNIT_Q31;
      for (n = 9; n >= 1; n--) begin
        t = UNIT_Q31 - (((x2 * t) >> 31) / 64'((2 * n) * (2 * n + 1)));
      end
      s   = (x * t) >> 31;
      mag = (64'(FULL_SCALE) * s + (64'd1 << 30)) >> 31;
      if (mag > 64'(FULL_SCALE)) begin
        mag = 64'(FULL_SCALE);
      end
      return ((q & 2) != 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function void note_tick(tone_tick_t tk);
      logic [SYMBOL_W-1:0] sym;
      logic [SYMBOL_W-1:0] tone;
      tone_sample_t        want;
      longint              v;
      longint              dg;
      longint              ng;
      longint              nz;
      int                  k;
      if (tk.start_req) begin
        sym  = (tk.symbol > REPEAT_TONE) ? REPEAT_TONE : tk.symbol;
        tone = sym;
        if (tk.is_digit && sym <= MAX_DIGIT) begin
          if (tk.first_of_number) begin
            was_replaced = 1'b0;
          end else if (sym[DIGIT_W-1:0] == prev_digit) begin
            if (was_replaced) begin
              was_replaced = 1'b0;
            end else begin
              tone         = REPEAT_TONE;
              was_replaced = 1'b1;
            end
          end else begin
            was_replaced = 1'b0;
          end
          prev_digit = sym[DIGIT_W-1:0];
        end
        phase_acc    = '0;
        phase_inc    = phase_inc_for(int'(tone));
        samples_left = tk.duration;
      end
      want = '0;
      if (samples_left != '0) begin
        phase_acc = phase_acc + phase_inc;
        k  = int'(phase_acc >> (PHASE_W - K_BITS));
        dg = longint'(drive_gain);
        ng = longint'(noise_gain);
        nz = longint'(tk.noise);
        v  = (sine_of(k) * dg) >>> 15;
        v  = v + ((nz * ng) >>> 16);
        if (v > FULL_SCALE) begin
          v = FULL_SCALE;
        end
        if (v < -FULL_SCALE) begin
          v = -FULL_SCALE;
        end
        samples_left = samples_left - DURATION_W'(1);
        want.sample  = v[SAMPLE_W-1:0];
        want.active  = 1'b1;
        want.last    = (samples_left == '0);
      end
      expected_samples.push_back(want);
    endfunction

    function void check_sample(tone_sample_t got);
      tone_sample_t want;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected item: sample=%0d active=%0b last=%0b",
                   got.sample, got.active, got.last);
        end
        return;
      end
      want = expected_samples.pop_front();
      if (got.sample !== want.sample || got.active !== want.active ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch: expected sample=%0d active=%0b last=%0b, %s",
                   want.sample, want.active, want.last,
                   $sformatf("got sample=%0d active=%0b last=%0b",
                             got.sample, got.active, got.last));
        end
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

endpackage

@@ tb/sv/tb_paging_tone_sequence_generator.sv @@
// Testbench top: random and directed tone items against a predicting scoreboard, with gain changes.
`timescale 1ns / 1ps

module tb_paging_tone_sequence_generator;

  import ptsg_pkg::*;
  import ptsg_tone_check_pkg::*;

  localparam int SETTING_COUNT  = 7;
  localparam int FIXED_SETTINGS = 5;
  localparam int ITEMS_PER_SET  = 270;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_SETTING   = 2;
  localparam int HOLD_CYCLES    = 400;

  localparam logic [GAIN_W-1:0] DRIVE_SET [FIXED_SETTINGS] = '{
    DRIVE_GAIN_RST, 16'd0, 16'd65535, 16'd65535, 16'd0
  };
  localparam logic [GAIN_W-1:0] NOISE_SET [FIXED_SETTINGS] = '{
    NOISE_GAIN_RST, 16'd0, 16'd65535, 16'd0, 16'd65535
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [GAIN_W-1:0]    cfg_wdata;
  logic                 rx_hold;
  logic                 tx_calm;
  logic                 rx_calm;
  int                   tx_count;
  int                   setting_no;

  ptsg_in_if  in_ch ();
  ptsg_out_if out_ch ();

  tone_scoreboard sb = new();

  paging_tone_sequence_generator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic tone_tick_t tick_of(bit st, int sym, bit dig, bit first, int dur, int nz);
    tone_tick_t tk;
    tk.start_req       = st;
    tk.symbol          = SYMBOL_W'(sym);
    tk.is_digit        = dig;
    tk.first_of_number = first;
    tk.duration        = DURATION_W'(dur);
    tk.noise           = NOISE_W'(nz);
    return tk;
  endfunction

  function automatic tone_tick_t plain_tick();
    return tick_of(1'b0, $urandom_range(0, 31), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                   $urandom_range(0, 65535));
  endfunction

  function automatic int tone_length();
    return ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 12);
  endfunction

  function automatic int following_ticks(int dur);
    if (dur == 0) begin
      return $urandom_range(0, 2);
    end
    if ($urandom_range(0, 99) < 15) begin
      return $urandom_range(0, dur - 1);
    end
    return dur - 1 + $urandom_range(0, 2);
  endfunction

  task automatic offer_tick(tone_tick_t tk);
    int gap;
    if (tx_count % 48 == 0) begin
      tx_calm = ($urandom_range(0, 2) == 0);
    end
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid           <= 1'b1;
    in_ch.start_req       <= tk.start_req;
    in_ch.symbol          <= tk.symbol;
    in_ch.is_digit        <= tk.is_digit;
    in_ch.first_of_number <= tk.first_of_number;
    in_ch.duration        <= tk.duration;
    in_ch.noise           <= tk.noise;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_tick(tk);
    tx_count++;
  endtask

  task automatic write_gains(logic [GAIN_W-1:0] dg, logic [GAIN_W-1:0] ng);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_DRIVE_GAIN;
    cfg_wdata <= dg;
    @(negedge clk);
    cfg_idx   <= CFG_NOISE_GAIN;
    cfg_wdata <= ng;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_gain(CFG_DRIVE_GAIN, dg);
    sb.set_gain(CFG_NOISE_GAIN, ng);
  endtask

  task automatic directed_ticks();
    offer_tick(tick_of(1'b0, 31, 1'b1, 1'b1, 65535, 65535));
    offer_tick(tick_of(1'b1, 0, 1'b1, 1'b1, 3, 0));
    offer_tick(tick_of(1'b0, 0, 1'b0, 1'b0, 0, 65535));
    offer_tick(tick_of(1'b0, 0, 1'b0, 1'b0, 0, 0));
    offer_tick(tick_of(1'b1, 0, 1'b1, 1'b0, 2, 32768));
    offer_tick(tick_of(1'b0, 0, 1'b0, 1'b0, 0, 1));
    offer_tick(tick_of(1'b1, 0, 1'b1, 1'b0, 1, 65535));
    offer_tick(tick_of(1'b1, 9, 1'b1, 1'b0, 1, 0));
    offer_tick(tick_of(1'b1, 9, 1'b1, 1'b0, 1, 0));
    offer_tick(tick_of(1'b1, 31, 1'b1, 1'b0, 2, 65535));
    offer_tick(tick_of(1'b0, 0, 1'b0, 1'b0, 0, 0));
    offer_tick(tick_of(1'b1, IDLE_SYMBOL, 1'b0, 1'b0, 0, 65535));
    offer_tick(tick_of(1'b1, 14, 1'b0, 1'b0, 65535, 0));
    offer_tick(tick_of(1'b0, 0, 1'b0, 1'b0, 0, 65535));
    offer_tick(tick_of(1'b0, 0, 1'b0, 1'b0, 0, 65535));
    offer_tick(tick_of(1'b1, 10, 1'b1, 1'b0, 4, 0));
    offer_tick(tick_of(1'b1, 3, 1'b1, 1'b1, 1, 12345));
    offer_tick(tick_of(1'b1, 3, 1'b1, 1'b1, 1, 54321));
    offer_tick(tick_of(1'b1, 12, 1'b0, 1'b0, 1, 0));
    offer_tick(tick_of(1'b0, 16, 1'b1, 1'b1, 1, 65535));
  endtask

  task automatic random_ticks(int count);
    int sent;
    int kind;
    int digits;
    int d;
    int digit;
    int prev;
    int dur;
    int run;
    sent = 0;
    prev = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        digits = $urandom_range(1, 8);
        for (d = 0; d < digits; d++) begin
          digit = ($urandom_range(0, 9) < 4) ? prev : $urandom_range(0, 9);
          dur   = tone_length();
          offer_tick(tick_of(1'b1, digit, 1'b1, d == 0, dur, $urandom_range(0, 65535)));
          prev = digit;
          run  = following_ticks(dur);
          repeat (run) offer_tick(plain_tick());
          sent += 1 + run;
        end
      end else if (kind < 85) begin
        dur = tone_length();
        offer_tick(tick_of(1'b1, $urandom_range(10, 16), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), dur, $urandom_range(0, 65535)));
        run = following_ticks(dur);
        repeat (run) offer_tick(plain_tick());
        sent += 1 + run;
      end else if (kind < 93) begin
        offer_tick(tick_of(1'b1, $urandom_range(0, 31), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                           $urandom_range(0, 65535)));
        run = $urandom_range(0, 5);
        repeat (run) offer_tick(plain_tick());
        sent += 1 + run;
      end else begin
        run = $urandom_range(1, 6);
        repeat (run) offer_tick(plain_tick());
        sent += run;
      end
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = CFG_DRIVE_GAIN;
    cfg_wdata             = '0;
    in_ch.valid           = 1'b0;
    in_ch.start_req       = 1'b0;
    in_ch.symbol          = '0;
    in_ch.is_digit        = 1'b0;
    in_ch.first_of_number = 1'b0;
    in_ch.duration        = '0;
    in_ch.noise           = '0;
    tx_calm               = 1'b0;
    tx_count              = 0;
    setting_no            = -1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < SETTING_COUNT; p++) begin
      setting_no = p;
      if (p < FIXED_SETTINGS) begin
        write_gains(DRIVE_SET[p], NOISE_SET[p]);
      end else begin
        write_gains(GAIN_W'($urandom_range(0, 65535)), GAIN_W'($urandom_range(0, 65535)));
      end
      if (p == 0) begin
        directed_ticks();
      end
      random_ticks(ITEMS_PER_SET);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // long receiver hold-off so the pipeline fills and back-pressures the input
  initial begin
    rx_hold = 1'b0;
    wait (setting_no == HOLD_SETTING);
    repeat (30) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    int           stall;
    int           rx_count;
    tone_sample_t got;
    out_ch.ready = 1'b0;
    rx_calm      = 1'b0;
    rx_count     = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_count % 40 == 0) begin
        rx_calm = ($urandom_range(0, 2) == 0);
      end
      stall = rx_calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      while (rx_hold) begin
        out_ch.ready <= 1'b0;
        @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.sample = out_ch.sample;
      got.active = out_ch.active;
      got.last   = out_ch.last;
      sb.check_sample(got);
      rx_count++;
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
